// ===== hw/rtl/mlpsig_pkg.sv =====
// Shared types, request codes and the sigmoid lookup table of the MLP inference core.
// Depends on nothing; every other file imports it.
`default_nettype none
package mlpsig_pkg;

    localparam int DEF_INPUT_NODES   = 8;
    localparam int DEF_HIDDEN_NODES  = 16;
    localparam int DEF_HIDDEN_LAYERS = 1;
    localparam int DEF_OUTPUT_NODES  = 4;

    localparam logic [1:0] REQ_WEIGHT  = 2'd0;
    localparam logic [1:0] REQ_BIAS    = 2'd1;
    localparam logic [1:0] REQ_FEATURE = 2'd2;

    typedef logic [15:0] sig_table_t [256];

    // Restoring division, only ever evaluated at elaboration time.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i stands for x = (i - 128) / 16; e^(-k/16) is built up step by step in Q32.
    function automatic sig_table_t build_sig_table();
        sig_table_t tab;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] v;
        logic [95:0] t;
        e = 64'd1 << 32;
        for (int k = 0; k <= 128; k++) begin
            if (k > 0) begin
                t = 96'(e) * 96'd4034748382 + (96'd1 << 31);
                e = t[95:32];
            end
            den = (64'd1 << 32) + e;
            if (k < 128) begin
                v = udiv64((64'd1 << 48) + (den >> 1), den);
                if (v > 64'd65535) begin
                    v = 64'd65535;
                end
                tab[128 + k] = v[15:0];
            end
            if (k > 0) begin
                v = udiv64((e << 16) + (den >> 1), den);
                tab[128 - k] = v[15:0];
            end
        end
        return tab;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

// ===== hw/rtl/mlp_sigmoid_inference_core.sv =====
// Forward pass of a fully connected sigmoid network on one shared multiply-accumulate unit.
// Depends on mlpsig_pkg for the request codes, the default sizes and the sigmoid table.
`default_nettype none
// Beats on the input stream load weights and biases (one beat a cycle) or deliver
// features; the feature beat with tlast set starts a pass, and the core then drops
// s_tready until the last output activation has been taken. For each node a pass
// fetches the bias, then for each product on the single 17x16 multiplier steps through
// address, multiply and accumulate, and ends with the table lookup; each result beat
// waits for as long as the sink holds it off. After reset the core zeroes its stores
// before s_tready first rises.
module mlp_sigmoid_inference_core #(
    parameter int INPUT_NODES   = mlpsig_pkg::DEF_INPUT_NODES,
    parameter int HIDDEN_NODES  = mlpsig_pkg::DEF_HIDDEN_NODES,
    parameter int HIDDEN_LAYERS = mlpsig_pkg::DEF_HIDDEN_LAYERS,
    parameter int OUTPUT_NODES  = mlpsig_pkg::DEF_OUTPUT_NODES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // addr [7:0], value [23:8]
    input  wire logic [1:0]  s_tuser,   // req_type [1:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // activation [15:0]
    output logic [1:0]       m_tuser,   // out_index [1:0]
    output logic             m_tlast
);
    import mlpsig_pkg::*;

    localparam int WC = INPUT_NODES * HIDDEN_NODES
                      + (HIDDEN_LAYERS - 1) * HIDDEN_NODES * HIDDEN_NODES
                      + HIDDEN_NODES * OUTPUT_NODES;
    localparam int BC = HIDDEN_LAYERS * HIDDEN_NODES + OUTPUT_NODES;
    localparam int CLR_MAX = (WC > BC) ? ((WC > INPUT_NODES) ? WC : INPUT_NODES)
                                       : ((BC > INPUT_NODES) ? BC : INPUT_NODES);
    localparam int WAW = $clog2(WC);
    localparam int BAW = $clog2(BC);
    localparam int FAW = (INPUT_NODES > 1) ? $clog2(INPUT_NODES) : 1;
    localparam int HAW = $clog2(2 * HIDDEN_NODES);
    localparam int CW  = $clog2(CLR_MAX + 1);
    localparam int FCW = $clog2(INPUT_NODES + 1);
    localparam int KMAX = (INPUT_NODES > HIDDEN_NODES) ? INPUT_NODES : HIDDEN_NODES;
    localparam int JMAX = (HIDDEN_NODES > OUTPUT_NODES) ? HIDDEN_NODES : OUTPUT_NODES;
    localparam int KW = (KMAX > 1) ? $clog2(KMAX) : 1;
    localparam int JW = (JMAX > 1) ? $clog2(JMAX) : 1;
    localparam int LW = $clog2(HIDDEN_LAYERS + 1);
    localparam int AW = 48;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_NODE  = 9'b000000100,
        ST_BIAS  = 9'b000001000,
        ST_RD    = 9'b000010000,
        ST_MUL   = 9'b000100000,
        ST_ACC   = 9'b001000000,
        ST_ACT   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]  clr_reg, clr_next;
    logic [FCW-1:0] fcnt_reg, fcnt_next;
    logic [LW-1:0]  layer_reg, layer_next;
    logic [JW-1:0]  j_reg, j_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [WAW-1:0] wbase_reg, wbase_next;
    logic [WAW-1:0] waddr_reg, waddr_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [32:0] mul_reg;
    logic [15:0] act_reg;
    logic [1:0]  oidx_reg;
    logic        olast_reg;

    logic [15:0] weight_mem [WC];
    logic [15:0] bias_mem [BC];
    logic [15:0] feat_mem [INPUT_NODES];
    logic [15:0] hid_mem [2 * HIDDEN_NODES];
    logic [15:0] w_rd_reg, b_rd_reg, f_rd_reg, h_rd_reg;

    logic [7:0]  in_addr;
    logic [15:0] in_value;
    logic        in_beat;
    logic        first_layer, out_layer;
    logic [KW-1:0] k_last;
    logic [WAW-1:0] w_step, layer_span;
    logic [BAW-1:0] b_rd_addr;
    logic [HAW-1:0] h_rd_addr, h_wr_addr;
    logic signed [16:0] mul_a;
    logic signed [AW-1:0] term;
    logic signed [31:0] q32;
    logic [15:0] q16;
    logic [15:0] act_val;
    logic w_we, b_we, f_we;
    logic [WAW-1:0] w_wa;
    logic [BAW-1:0] b_wa;
    logic [FAW-1:0] f_wa;
    logic [15:0] wr_data;

    assign in_addr  = s_tdata[7:0];
    assign in_value = s_tdata[23:8];
    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign first_layer = (layer_reg == '0);
    assign out_layer   = (layer_reg == LW'(HIDDEN_LAYERS));
    assign k_last      = first_layer ? KW'(INPUT_NODES - 1) : KW'(HIDDEN_NODES - 1);
    assign w_step      = out_layer ? WAW'(OUTPUT_NODES) : WAW'(HIDDEN_NODES);
    assign layer_span  = first_layer ? WAW'(INPUT_NODES * HIDDEN_NODES)
                                     : WAW'(HIDDEN_NODES * HIDDEN_NODES);
    assign b_rd_addr   = BAW'(layer_reg * HIDDEN_NODES) + BAW'(j_reg);
    // Hidden layers alternate between two banks: write layer l into bank l[0].
    assign h_rd_addr   = (layer_reg[0] ? HAW'(0) : HAW'(HIDDEN_NODES)) + HAW'(k_reg);
    assign h_wr_addr   = (layer_reg[0] ? HAW'(HIDDEN_NODES) : HAW'(0)) + HAW'(j_reg);

    // Features are signed Q4.12; hidden activations are unsigned Q0.16.
    assign mul_a = first_layer ? {f_rd_reg[15], f_rd_reg} : {1'b0, h_rd_reg};
    assign term  = first_layer ? (AW'(mul_reg) <<< 4) : AW'(mul_reg);

    // Arithmetic shift gives the floor; then saturate to Q4.12 and index the table.
    assign q32 = acc_reg[47:16];
    always_comb begin
        if (q32 > 32'sd32767) begin
            q16 = 16'h7FFF;
        end else if (q32 < -32'sd32768) begin
            q16 = 16'h8000;
        end else begin
            q16 = q32[15:0];
        end
    end
    assign act_val = SIG_TABLE[{~q16[15], q16[14:8]}];

    // Store write ports: the clearing sweep after reset, otherwise load beats.
    always_comb begin
        w_we = 1'b0;
        b_we = 1'b0;
        f_we = 1'b0;
        w_wa = WAW'(in_addr);
        b_wa = BAW'(in_addr);
        f_wa = FAW'(fcnt_reg);
        wr_data = in_value;
        if (state_reg == ST_CLEAR) begin
            w_wa = WAW'(clr_reg);
            b_wa = BAW'(clr_reg);
            f_wa = FAW'(clr_reg);
            wr_data = '0;
            w_we = (32'(clr_reg) < WC);
            b_we = (32'(clr_reg) < BC);
            f_we = (32'(clr_reg) < INPUT_NODES);
        end else if (in_beat) begin
            w_we = (s_tuser == REQ_WEIGHT) && (32'(in_addr) < WC);
            b_we = (s_tuser == REQ_BIAS) && (32'(in_addr) < BC);
            f_we = (s_tuser == REQ_FEATURE) && (32'(fcnt_reg) < INPUT_NODES);
        end
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            weight_mem[w_wa] <= wr_data;
        end
        if (b_we) begin
            bias_mem[b_wa] <= wr_data;
        end
        if (f_we) begin
            feat_mem[f_wa] <= wr_data;
        end
        if (state_reg == ST_ACT && !out_layer) begin
            hid_mem[h_wr_addr] <= act_val;
        end
        w_rd_reg <= weight_mem[waddr_reg];
        b_rd_reg <= bias_mem[b_rd_addr];
        f_rd_reg <= feat_mem[FAW'(k_reg)];
        h_rd_reg <= hid_mem[h_rd_addr];
        mul_reg  <= mul_a * $signed(w_rd_reg);
        if (state_reg == ST_ACT) begin
            act_reg   <= act_val;
            oidx_reg  <= 2'(j_reg);
            olast_reg <= (j_reg == JW'(OUTPUT_NODES - 1));
        end
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        fcnt_next  = fcnt_reg;
        layer_next = layer_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        wbase_next = wbase_reg;
        waddr_next = waddr_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CLR_MAX - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_beat && s_tuser == REQ_FEATURE) begin
                    if (32'(fcnt_reg) < INPUT_NODES) begin
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        fcnt_next  = '0;
                        layer_next = '0;
                        j_next     = '0;
                        wbase_next = '0;
                        state_next = ST_NODE;
                    end
                end
            end
            ST_NODE: begin
                k_next     = '0;
                waddr_next = wbase_reg + WAW'(j_reg);
                state_next = ST_BIAS;
            end
            ST_BIAS: begin
                acc_next   = AW'($signed(b_rd_reg)) <<< 16;
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = acc_reg + term;
                waddr_next = waddr_reg + w_step;
                k_next     = k_reg + 1'b1;
                state_next = (k_reg == k_last) ? ST_ACT : ST_RD;
            end
            ST_ACT: begin
                if (out_layer) begin
                    state_next = ST_OUT;
                end else if (j_reg == JW'(HIDDEN_NODES - 1)) begin
                    j_next     = '0;
                    layer_next = layer_reg + 1'b1;
                    wbase_next = wbase_reg + layer_span;
                    state_next = ST_NODE;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_NODE;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (j_reg == JW'(OUTPUT_NODES - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_NODE;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            fcnt_reg  <= '0;
            layer_reg <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            wbase_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            fcnt_reg  <= fcnt_next;
            layer_reg <= layer_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            wbase_reg <= wbase_next;
        end
    end

    always_ff @(posedge aclk) begin
        waddr_reg <= waddr_next;
        acc_reg   <= acc_next;
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = act_reg;
    assign m_tuser  = oidx_reg;
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/mlpsig_checker.sv =====
// Port-level checks for the MLP inference core, with the bind that attaches them.
// Depends on mlp_sigmoid_inference_core and mlpsig_pkg.
`default_nettype none
module mlpsig_checker #(
    parameter int OUTPUT_NODES = mlpsig_pkg::DEF_OUTPUT_NODES
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import mlpsig_pkg::*;

    localparam logic [1:0] LAST_IDX = 2'(OUTPUT_NODES - 1);

    // A result beat held back by the sink keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // The core never takes input while it is presenting a result.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // A final feature beat closes the input side for the pass.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_FEATURE && s_tlast |=> !s_tready)
        else $error("input still ready after pass start");

    // The last result carries the index of the final output node.
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == LAST_IDX)
        else $error("last result with wrong node index");

    // After a non-final result the next node still has to be computed.
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid && !s_tready)
        else $error("result without computation gap");

endmodule

bind mlp_sigmoid_inference_core mlpsig_checker #(
    .OUTPUT_NODES(OUTPUT_NODES)
) u_mlpsig_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
